/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tone mixer design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STVM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/stvm_pkg.sv */
// ----------------------------------------------------------------------------
// stvm_pkg
// Types, constants and codes shared by the square-wave tone mixer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stvm_pkg;

    localparam int VOICES_DEF    = 8;
    localparam int BLOCK_LEN_DEF = 512;

    localparam int FREQ_W   = 15;
    localparam int VOL_W    = 8;
    localparam int DUR_W    = 16;
    localparam int DURX_W   = 25;
    localparam int PHASE_W  = 16;
    localparam int QUOT_W   = 16;
    localparam int TICKS_W  = 22;
    localparam int SAMPLE_W = 16;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // Duration in ms times 44100/1000, reduced to times 441 then divided by 10.
    localparam logic [QUOT_W-1:0] AUDIO_RATE = 16'd44100;
    localparam logic [8:0]        DUR_SCALE  = 9'd441;

    // Division by 10 as a multiply by reciprocal, exact for 32-bit operands.
    localparam logic [31:0] RECIP10_MUL   = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;
    localparam int          TPROD_W       = DURX_W + 32;

    // Division by 255 as a multiply by reciprocal, exact below 2^24.
    localparam logic [23:0] DIV255_MUL   = 24'd8421505;
    localparam int          DIV255_SHIFT = 31;
    localparam int          SCALE_W      = 24;

    localparam logic [VOL_W-1:0] MASTER_RESET = 8'd255;

    localparam int QDEPTH = 2;
    localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [1:0] {
        STAT_SAMPLE = 2'd0,
        STAT_ACCEPT = 2'd1,
        STAT_DROP   = 2'd2
    } t_status;

    typedef struct packed {
        logic              op;
        logic [FREQ_W-1:0] freq;
        logic [VOL_W-1:0]  vol;
        logic [DURX_W-1:0] dur_x441;
    } t_cmd;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [QUOT_W-1:0]  period;
        logic [TICKS_W-1:0] ticks;
        logic [VOL_W-1:0]   vol;
    } t_voice;

endpackage

`default_nettype wire

/* design/stvm_ram.sv */
// ----------------------------------------------------------------------------
// stvm_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire logic [WIDTH-1:0]       i_wdata,
    input  wire logic                   i_re,
    input  wire logic [AW-1:0]          i_raddr,
    output logic      [WIDTH-1:0]       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* design/stvm_div.sv */
// ----------------------------------------------------------------------------
// stvm_div
// Restoring divider that turns a tone frequency into a period in samples.
// ----------------------------------------------------------------------------
`default_nettype none

module stvm_div
    import stvm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [FREQ_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [QUOT_W-1:0]      o_quotient
);

    localparam int CW = $clog2(QUOT_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(QUOT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [QUOT_W-1:0] r_rem;
    logic [QUOT_W-1:0] r_quo;
    logic [FREQ_W-1:0] r_div;

    logic [QUOT_W-1:0] rem_sh;
    logic              ge;

    // One quotient bit per cycle; the dividend shifts out of r_quo as the
    // quotient shifts in.
    always_comb begin
        rem_sh = {r_rem[QUOT_W-2:0], r_quo[QUOT_W-1]};
        ge     = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
            r_done <= !i_start && r_busy && (r_cnt == LAST_STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= AUDIO_RATE;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
            r_quo <= {r_quo[QUOT_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* design/stvm_front.sv */
// ----------------------------------------------------------------------------
// stvm_front
// Input side: unpacks and classifies stream items into a short command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stvm_front
    import stvm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [0:0]           i_s_tuser,
    output logic                      o_cmd_valid,
    input  wire logic                 i_cmd_ready,
    output t_cmd                      o_cmd
);

    t_cmd            r_mem [QDEPTH];
    logic [QPW-1:0]  r_wr_ptr;
    logic [QPW-1:0]  r_rd_ptr;
    logic [QPW:0]    r_count;

    t_cmd              cmd_in;
    logic [FREQ_W-1:0] freq_in;
    logic [DUR_W-1:0]  dur_in;
    logic              push;
    logic              pop;

    always_comb begin
        freq_in = i_s_tdata[FREQ_W-1:0];
        dur_in  = i_s_tdata[FREQ_W+VOL_W +: DUR_W];
        cmd_in.op   = i_s_tuser[0];
        // A zero frequency plays as 1 Hz.
        cmd_in.freq = (freq_in == '0) ? FREQ_W'(1) : freq_in;
        cmd_in.vol  = i_s_tdata[FREQ_W +: VOL_W];
        cmd_in.dur_x441 = DURX_W'(dur_in) * DURX_W'(DUR_SCALE);
    end

    assign o_s_tready  = (r_count != (QPW+1)'(QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign push        = i_s_tvalid && o_s_tready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

/* design/stvm_back.sv */
// ----------------------------------------------------------------------------
// stvm_back
// Execution side: voice allocation, per-voice tick pipeline and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stvm_back
    import stvm_pkg::*;
#(
    parameter int VOICES    = VOICES_DEF,
    parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cmd_valid,
    output logic                      o_cmd_ready,
    input  wire t_cmd                 i_cmd,
    input  wire logic                 i_cfg_valid,
    input  wire logic [VOL_W-1:0]     i_cfg_data,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    output logic [1:0]                o_m_tuser
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int BW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);
    localparam logic [BW-1:0] LAST_POS   = BW'(BLOCK_LEN - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_TICK,
        S_DRAIN,
        S_RESULT
    } t_state;

    t_state                r_state;
    logic [VOL_W-1:0]      r_master;
    logic [VOICES-1:0]     r_active;
    logic [VOICES-1:0]     r_expired;
    logic [BW-1:0]         r_blk_pos;
    logic [VW-1:0]         r_idx;
    logic [VW-1:0]         r_slot;
    logic [FREQ_W-1:0]     r_freq;
    logic [VOL_W-1:0]      r_vol;
    logic [TPROD_W-1:0]    r_tprod;
    logic [SAMPLE_W-1:0]   r_sum;
    logic [SAMPLE_W-1:0]   r_res_sample;
    t_status               r_res_status;
    logic                  r_out_valid;
    logic [SAMPLE_W-1:0]   r_out_data;
    t_status               r_out_user;

    // Tick pipeline: RAM data, magnitude, master gain, divide by 255, sum.
    logic                  r_p1_valid;
    logic [VW-1:0]         r_p1_idx;
    logic                  r_p2_valid;
    logic [SAMPLE_W-1:0]   r_p2_abs;
    logic                  r_p2_neg;
    logic                  r_p3_valid;
    logic [SCALE_W-1:0]    r_p3_a;
    logic                  r_p3_neg;
    logic                  r_p4_valid;
    logic [SAMPLE_W-1:0]   r_p4_q;
    logic                  r_p4_neg;

    logic                  div_start;
    logic                  div_done;
    logic [QUOT_W-1:0]     div_quot;
    logic [TICKS_W-1:0]    new_ticks;
    logic                  ram_we;
    logic [VW-1:0]         ram_waddr;
    t_voice                ram_wdata;
    logic                  ram_re;
    t_voice                ram_rdata;
    t_voice                p1_next;
    logic [PHASE_W:0]      ph_inc;
    logic                  ph_pos;
    logic [SAMPLE_W-1:0]   p1_mag;
    logic [SAMPLE_W-1:0]   p1_raw;
    logic [SAMPLE_W-1:0]   p1_abs;
    logic                  p1_neg;
    logic [2*SCALE_W-1:0]  p3_prod;
    logic                  pipe_busy;
    logic                  out_free;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign div_start   = (r_state == S_SCAN) && !r_active[r_idx];
    assign new_ticks   = r_tprod[RECIP10_SHIFT +: TICKS_W];
    assign ram_re      = (r_state == S_TICK);
    assign pipe_busy   = r_p1_valid || r_p2_valid || r_p3_valid || r_p4_valid;
    assign out_free    = !r_out_valid || i_m_tready;
    assign p3_prod     = (2*SCALE_W)'(r_p3_a) * (2*SCALE_W)'(DIV255_MUL);

    // Phase step, tick countdown and the square-wave level of one voice.
    always_comb begin
        p1_next = ram_rdata;
        ph_inc  = {1'b0, ram_rdata.phase} + 1'b1;
        if (ph_inc > {1'b0, ram_rdata.period}) begin
            p1_next.phase = '0;
        end else begin
            p1_next.phase = ph_inc[PHASE_W-1:0];
        end
        p1_next.ticks = (ram_rdata.ticks != '0) ? ram_rdata.ticks - 1'b1 : '0;
        ph_pos = (p1_next.phase > (ram_rdata.period >> 1));
        p1_mag = {ram_rdata.vol, 8'd0} - {8'd0, ram_rdata.vol};
        p1_raw = ph_pos ? p1_mag : (SAMPLE_W'(0) - p1_mag);
        p1_neg = p1_raw[SAMPLE_W-1];
        p1_abs = p1_neg ? (SAMPLE_W'(0) - p1_raw) : p1_raw;
    end

    always_comb begin
        if ((r_state == S_DIV) && div_done) begin
            ram_we           = 1'b1;
            ram_waddr        = r_slot;
            ram_wdata.phase  = '0;
            ram_wdata.period = div_quot;
            ram_wdata.ticks  = new_ticks;
            ram_wdata.vol    = r_vol;
        end else begin
            ram_we    = r_p1_valid;
            ram_waddr = r_p1_idx;
            ram_wdata = p1_next;
        end
    end

    stvm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (r_freq),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    stvm_ram #(
        .WIDTH ($bits(t_voice)),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_master    <= MASTER_RESET;
            r_active    <= '0;
            r_expired   <= '0;
            r_blk_pos   <= '0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_master <= i_cfg_data;
            end
            if (r_out_valid && i_m_tready && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            if (r_p1_valid) begin
                r_expired[r_p1_idx] <= (p1_next.ticks == '0);
            end
            if (r_p4_valid) begin
                r_sum <= r_sum + (r_p4_neg ? (SAMPLE_W'(0) - r_p4_q) : r_p4_q);
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_idx   <= '0;
                        r_freq  <= i_cmd.freq;
                        r_vol   <= i_cmd.vol;
                        r_tprod <= TPROD_W'(i_cmd.dur_x441) * TPROD_W'(RECIP10_MUL);
                        if (i_cmd.op == OP_START) begin
                            r_state <= S_SCAN;
                        end else if (r_active == '0) begin
                            // Idle tick: silence, and the block restarts.
                            r_blk_pos    <= '0;
                            r_res_sample <= '0;
                            r_res_status <= STAT_SAMPLE;
                            r_state      <= S_RESULT;
                        end else begin
                            r_sum   <= '0;
                            r_state <= S_TICK;
                        end
                    end
                end
                S_SCAN: begin
                    if (!r_active[r_idx]) begin
                        r_slot  <= r_idx;
                        r_state <= S_DIV;
                    end else if (r_idx == LAST_VOICE) begin
                        r_res_sample <= '0;
                        r_res_status <= STAT_DROP;
                        r_state      <= S_RESULT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_active[r_slot]  <= 1'b1;
                        r_expired[r_slot] <= (new_ticks == '0);
                        r_res_sample      <= '0;
                        r_res_status      <= STAT_ACCEPT;
                        r_state           <= S_RESULT;
                    end
                end
                S_TICK: begin
                    if (r_idx == LAST_VOICE) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!pipe_busy) begin
                        r_res_sample <= r_sum;
                        r_res_status <= STAT_SAMPLE;
                        // Expired voices are released only at a block boundary.
                        if (r_blk_pos == LAST_POS) begin
                            r_active  <= r_active & ~r_expired;
                            r_blk_pos <= '0;
                        end else begin
                            r_blk_pos <= r_blk_pos + 1'b1;
                        end
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res_sample;
                        r_out_user  <= r_res_status;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
        end else begin
            r_p1_valid <= (r_state == S_TICK) && r_active[r_idx];
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_idx <= r_idx;
        r_p2_abs <= p1_abs;
        r_p2_neg <= p1_neg;
        r_p3_a   <= SCALE_W'(r_p2_abs) * SCALE_W'(r_master);
        r_p3_neg <= r_p2_neg;
        r_p4_q   <= p3_prod[DIV255_SHIFT +: SAMPLE_W];
        r_p4_neg <= r_p3_neg;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire

/* design/square_tone_voice_mixer_core.sv */
// ----------------------------------------------------------------------------
// square_tone_voice_mixer_core
// Polyphonic square-wave tone mixer producing a 16-bit sample stream.
// ----------------------------------------------------------------------------
// Input stream: tuser[0] is the operation (0 = sample tick, 1 = start tone);
// tdata carries frequency, tone volume and duration for a start.
// Output stream: one result per input, tdata the mixed sample, tuser the
// status (sample, tone accepted, tone dropped because all voices are busy).
// Configuration channel: master volume, to be written by the user only while
// the block is idle; the block itself does not enforce this. A tick with
// active voices reads the voice RAM one voice per cycle into a four-stage
// scaling pipeline, which then drains; a tick with no voice active returns
// silence. An accepted start is a scan for the lowest free voice, then a
// restoring divide for the period; a dropped start finds no free voice.
// Items are processed one at a time; a two-entry input queue and the output
// register let input be taken while a result waits on a stalled receiver.
// Reset frees all voices, restarts the block counter and sets the master
// volume to full scale; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module square_tone_voice_mixer_core
    import stvm_pkg::*;
#(
    parameter int VOICES    = VOICES_DEF,
    parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // frequency[14:0], tone_volume[22:15], duration_ms[38:23], zero[39]
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // op[0]
    input  wire logic [0:0]           i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // mixed_sample[15:0]
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    // status[1:0]
    output logic [1:0]                o_m_tuser,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [VOL_W-1:0]     i_cfg_data
);

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    stvm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    stvm_back #(
        .VOICES    (VOICES),
        .BLOCK_LEN (BLOCK_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // A start result never carries sample data.
    `STVM_ASSERT_IMPL(a_start_result_silent, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != STAT_SAMPLE), o_m_tdata == '0, "start result carries a nonzero sample")

    // Input back-pressure only happens when the queue holds work.
    `STVM_ASSERT_IMPL(a_stall_means_queued, i_clk, i_rst_n, !o_s_tready, cmd_valid, "input stalled while the command queue is empty")

    // A queued command stays offered until the execution side takes it.
    `STVM_ASSERT_NEXT(a_queue_holds, i_clk, i_rst_n, cmd_valid && !cmd_ready, cmd_valid, "queued command lost before it was taken")

endmodule

`default_nettype wire
